// File: design/obnf_pkg.sv
// shared constants, types and helpers of the online box nms filter
package obnf_pkg;

    localparam int MAX_BOXES  = 32;
    localparam int COORD_BITS = 14;
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    localparam int IMG_W      = 13;
    localparam int SCORE_W    = 16;
    localparam int PAD_W      = 8;
    localparam int LIMIT_W    = 26;
    localparam int CFG_W      = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_IN_W  = SCORE_W + IMG_W;
    localparam int DEC_W      = 18;
    localparam int SPAN_W     = COORD_BITS + 2;
    localparam int INTER_W    = 2 * (COORD_BITS + 1);
    localparam int AREA_W     = 2 * COORD_BITS;
    localparam int UNI_W      = INTER_W + 2;
    localparam int PROD_W     = SCORE_W + UNI_W - 1;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_FORMAT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_THR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_PIXELS   = 3'd6;

    localparam logic FMT_CENTER = 1'b0;
    localparam logic FMT_CORNER = 1'b1;
    localparam logic FUNC_DET   = 1'b0;
    localparam logic FUNC_EOF   = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic signed [COORD_BITS-1:0] width;
        logic signed [COORD_BITS-1:0] height;
        logic [SCORE_W-1:0]           score;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_SCAN,
        S_COMMIT,
        S_EMIT
    } t_state;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [DEC_W-1:0] v);
        logic signed [DEC_W-1:0] hi;
        logic signed [DEC_W-1:0] lo;
        logic signed [DEC_W-1:0] r;
        hi = (DEC_W'(1) <<< (COORD_BITS - 1)) - DEC_W'(1);
        lo = -(DEC_W'(1) <<< (COORD_BITS - 1));
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end else begin
            r = v;
        end
        return r[COORD_BITS-1:0];
    endfunction

endpackage

// File: design/obnf_cell.sv
// one storage cell of the kept box chain
module obnf_cell (
    input  logic               i_clk,
    input  obnf_pkg::t_cell_ctl i_ctl,
    input  obnf_pkg::t_entry   i_next,
    input  obnf_pkg::t_entry   i_push,
    output obnf_pkg::t_entry   o_entry
);
    import obnf_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_push;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
endmodule

// File: design/obnf_decode.sv
// scaling, box decode, saturation and area check of a detection
module obnf_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [obnf_pkg::SCORE_W-1:0]  i_score,
    input  logic [15:0]                   i_coord_a,
    input  logic [15:0]                   i_coord_b,
    input  logic [15:0]                   i_coord_c,
    input  logic [15:0]                   i_coord_d,
    input  logic                          i_fmt,
    input  logic [obnf_pkg::IMG_W-1:0]    i_img_w,
    input  logic [obnf_pkg::IMG_W-1:0]    i_img_h,
    input  logic [obnf_pkg::PAD_W-1:0]    i_pad,
    input  logic [obnf_pkg::LIMIT_W-1:0]  i_limit,
    output logic                          o_valid,
    output obnf_pkg::t_entry              o_box,
    output logic signed [obnf_pkg::AREA_W-1:0] o_area,
    output logic                          o_add
);
    import obnf_pkg::*;

    logic                  r_v1, r_v2, r_v3;
    logic [PROD_IN_W-1:0]  r_pa, r_pb, r_pc, r_pd;
    logic [SCORE_W-1:0]    r_s1;
    t_entry                r_box2, r_box3;
    logic signed [AREA_W-1:0] r_area;

    logic signed [DEC_W-1:0] va, vb, vc, vd, half, padx;
    logic signed [DEC_W-1:0] bw, bh, x0, y0, dl, dt, dw, dh;
    logic signed [31:0]      area_ext;

    always_comb begin
        va   = DEC_W'(r_pa[PROD_IN_W-1:16]);
        vb   = DEC_W'(r_pb[PROD_IN_W-1:16]);
        vc   = DEC_W'(r_pc[PROD_IN_W-1:16]);
        vd   = DEC_W'(r_pd[PROD_IN_W-1:16]);
        padx = DEC_W'(i_pad);
        half = DEC_W'(i_pad[PAD_W-1:1]);
        bw   = vc + padx;
        bh   = vd + padx;
        x0   = va - half;
        y0   = vb - half;
        if (i_fmt == FMT_CENTER) begin
            dl = va - (bw >>> 1);
            dt = vb - (bh >>> 1);
            dw = bw;
            dh = bh;
        end else begin
            dl = x0;
            dt = y0;
            dw = (vc + half) - x0;
            dh = (vd + half) - y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_pa          <= i_coord_a * i_img_w;
        r_pb          <= i_coord_b * i_img_h;
        r_pc          <= i_coord_c * i_img_w;
        r_pd          <= i_coord_d * i_img_h;
        r_s1          <= i_score;
        r_box2.left   <= sat_coord(dl);
        r_box2.top    <= sat_coord(dt);
        r_box2.width  <= sat_coord(dw);
        r_box2.height <= sat_coord(dh);
        r_box2.score  <= r_s1;
        r_box3        <= r_box2;
        r_area        <= r_box2.width * r_box2.height;
    end

    assign area_ext = 32'(r_area);
    assign o_valid  = r_v3;
    assign o_box    = r_box3;
    assign o_area   = r_area;
    assign o_add    = !(i_fmt == FMT_CORNER && i_limit != '0 &&
                        area_ext > $signed({6'd0, i_limit}));
endmodule

// File: design/obnf_iou.sv
// pipelined overlap test of one kept box against the new box
module obnf_iou (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  obnf_pkg::t_entry              i_entry,
    input  obnf_pkg::t_entry              i_new,
    input  logic signed [obnf_pkg::AREA_W-1:0] i_new_area,
    input  logic [obnf_pkg::SCORE_W-1:0]  i_thr,
    output logic                          o_valid,
    output logic                          o_keep,
    output logic                          o_block,
    output obnf_pkg::t_entry              o_entry,
    output logic                          o_busy
);
    import obnf_pkg::*;

    logic                     r_v1, r_v2, r_v3, r_v4;
    t_entry                   r_e1, r_e2, r_e3, r_e4;
    logic                     r_d1, r_d2, r_d3;
    logic signed [SPAN_W-1:0] r_dx, r_dy;
    logic [INTER_W-1:0]       r_inter2, r_inter3;
    logic signed [AREA_W-1:0] r_ae;
    logic signed [UNI_W-1:0]  r_uni;
    logic                     r_keep, r_block;

    logic signed [COORD_BITS:0]   ex2, nx2, ey2, ny2, x2, y2;
    logic signed [COORD_BITS-1:0] x1, y1;
    logic signed [SPAN_W-1:0]     dx, dy;
    logic signed [UNI_W-1:0]      uni;
    logic [PROD_W-1:0]            rhs, lhs;
    logic                         conflict, lower;

    always_comb begin
        ex2 = {i_entry.left[COORD_BITS-1], i_entry.left} +
              {i_entry.width[COORD_BITS-1], i_entry.width};
        nx2 = {i_new.left[COORD_BITS-1], i_new.left} +
              {i_new.width[COORD_BITS-1], i_new.width};
        ey2 = {i_entry.top[COORD_BITS-1], i_entry.top} +
              {i_entry.height[COORD_BITS-1], i_entry.height};
        ny2 = {i_new.top[COORD_BITS-1], i_new.top} +
              {i_new.height[COORD_BITS-1], i_new.height};
        x1  = (i_entry.left > i_new.left) ? i_entry.left : i_new.left;
        y1  = (i_entry.top > i_new.top) ? i_entry.top : i_new.top;
        x2  = (ex2 < nx2) ? ex2 : nx2;
        y2  = (ey2 < ny2) ? ey2 : ny2;
        dx  = {x2[COORD_BITS], x2} - {{2{x1[COORD_BITS-1]}}, x1};
        dy  = {y2[COORD_BITS], y2} - {{2{y1[COORD_BITS-1]}}, y1};
        uni = {{(UNI_W-AREA_W){r_ae[AREA_W-1]}}, r_ae} +
              {{(UNI_W-AREA_W){i_new_area[AREA_W-1]}}, i_new_area} -
              {2'b00, r_inter2};
    end

    always_comb begin
        rhs      = i_thr * r_uni[UNI_W-2:0];
        lhs      = {1'b0, r_inter3, 16'd0};
        conflict = !r_d3 && !r_uni[UNI_W-1] && r_uni != '0 && lhs > rhs;
        lower    = r_e3.score < i_new.score;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_e1     <= i_entry;
        r_dx     <= dx;
        r_dy     <= dy;
        r_d1     <= dx[SPAN_W-1] | dy[SPAN_W-1];
        r_e2     <= r_e1;
        r_d2     <= r_d1;
        r_inter2 <= r_dx[COORD_BITS:0] * r_dy[COORD_BITS:0];
        r_ae     <= r_e1.width * r_e1.height;
        r_e3     <= r_e2;
        r_d3     <= r_d2;
        r_inter3 <= r_inter2;
        r_uni    <= uni;
        r_e4     <= r_e3;
        r_keep   <= !(conflict && lower);
        r_block  <= conflict && !lower;
    end

    assign o_valid = r_v4;
    assign o_keep  = r_keep;
    assign o_block = r_block;
    assign o_entry = r_e4;
    assign o_busy  = r_v1 | r_v2 | r_v3 | r_v4;
endmodule

// File: design/online_box_nms_filter_core.sv
// top level of the online box nms filter: control, cell chain and result register
// Kept boxes live in a chain of cells that shifts towards the head. A detection passes
// the decode pipeline, then every kept box leaves the head, one per cycle, passes a
// 4-stage overlap pipeline and is written back at the tail unless suppressed; the scan
// ends once the pipeline drains and a commit state appends the new box. The input takes
// the next request only back in idle, after the commit. A detection at or below the
// score threshold is dropped and leaves the filter idle.
// An end of frame sends one result per cycle that the sink takes, oldest box first, or
// one marker with tuser low when nothing is kept, and clears the store and overflow flag.
module online_box_nms_filter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // score, coord_a, coord_b, coord_c, coord_d
    input  logic [79:0]                      i_s_axis_tdata,
    // func
    input  logic [0:0]                       i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // box_left, box_top, box_width, box_height, box_score, overflow
    output logic [79:0]                      o_m_axis_tdata,
    // box_valid
    output logic [0:0]                       o_m_axis_tuser,
    output logic                             o_m_axis_tlast,
    input  logic                             i_cfg_we,
    input  logic [obnf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [obnf_pkg::CFG_W-1:0]       i_cfg_data
);
    import obnf_pkg::*;

    logic               r_fmt;
    logic [IMG_W-1:0]   r_img_w, r_img_h;
    logic [SCORE_W-1:0] r_score_thr, r_ovl_thr;
    logic [LIMIT_W-1:0] r_limit;
    logic [PAD_W-1:0]   r_pad;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt, r_todo, n_todo, tail;
    logic               r_add, n_add, r_ovf, n_ovf, r_empty, n_empty;
    t_entry             r_new;
    logic signed [AREA_W-1:0] r_new_area;

    logic               r_ovalid, n_ovalid;
    t_entry             r_obox;
    logic               r_obox_valid, r_oovf, r_olast;
    logic               load_out, out_marker, out_last;

    logic               in_acc, dec_start, pop, push;
    t_entry             push_data;
    t_entry             cell_q [MAX_BOXES];
    t_cell_ctl          cell_ctl [MAX_BOXES];

    logic               dec_valid, dec_add;
    t_entry             dec_box;
    logic signed [AREA_W-1:0] dec_area;
    logic               iou_valid, iou_keep, iou_block, iou_busy;
    t_entry             iou_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= FMT_CENTER;
            r_img_w     <= IMG_W'(416);
            r_img_h     <= IMG_W'(416);
            r_score_thr <= SCORE_W'(6554);
            r_ovl_thr   <= SCORE_W'(19661);
            r_limit     <= '0;
            r_pad       <= PAD_W'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BOX_FORMAT:   r_fmt       <= i_cfg_data[0];
                REG_IMAGE_WIDTH:  r_img_w     <= i_cfg_data[IMG_W-1:0];
                REG_IMAGE_HEIGHT: r_img_h     <= i_cfg_data[IMG_W-1:0];
                REG_SCORE_THR:    r_score_thr <= i_cfg_data[SCORE_W-1:0];
                REG_OVERLAP_THR:  r_ovl_thr   <= i_cfg_data[SCORE_W-1:0];
                REG_AREA_LIMIT:   r_limit     <= i_cfg_data[LIMIT_W-1:0];
                REG_PAD_PIXELS:   r_pad       <= i_cfg_data[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign dec_start       = in_acc && i_s_axis_tuser[0] == FUNC_DET &&
                             i_s_axis_tdata[15:0] > r_score_thr;

    obnf_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (dec_start),
        .i_score   (i_s_axis_tdata[15:0]),
        .i_coord_a (i_s_axis_tdata[31:16]),
        .i_coord_b (i_s_axis_tdata[47:32]),
        .i_coord_c (i_s_axis_tdata[63:48]),
        .i_coord_d (i_s_axis_tdata[79:64]),
        .i_fmt     (r_fmt),
        .i_img_w   (r_img_w),
        .i_img_h   (r_img_h),
        .i_pad     (r_pad),
        .i_limit   (r_limit),
        .o_valid   (dec_valid),
        .o_box     (dec_box),
        .o_area    (dec_area),
        .o_add     (dec_add)
    );

    obnf_iou u_iou (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_state == S_SCAN && r_todo != '0),
        .i_entry    (cell_q[0]),
        .i_new      (r_new),
        .i_new_area (r_new_area),
        .i_thr      (r_ovl_thr),
        .o_valid    (iou_valid),
        .o_keep     (iou_keep),
        .o_block    (iou_block),
        .o_entry    (iou_entry),
        .o_busy     (iou_busy)
    );

    always_comb begin
        n_state    = r_state;
        n_todo     = r_todo;
        n_add      = r_add;
        n_ovf      = r_ovf;
        n_empty    = r_empty;
        pop        = 1'b0;
        push       = 1'b0;
        push_data  = iou_entry;
        load_out   = 1'b0;
        out_marker = 1'b0;
        out_last   = 1'b0;
        if (iou_valid && iou_block) begin
            n_add = 1'b0;
        end
        if (iou_valid && iou_keep) begin
            push = 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_s_axis_tuser[0] == FUNC_EOF) begin
                    n_empty = (r_cnt == '0);
                    n_state = S_EMIT;
                end else if (dec_start) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (dec_valid) begin
                    n_add   = dec_add;
                    n_todo  = r_cnt;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_todo != '0) begin
                    pop    = 1'b1;
                    n_todo = r_todo - CNT_W'(1);
                end else if (!iou_busy) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (r_add) begin
                    if (r_cnt >= CNT_W'(MAX_BOXES)) begin
                        n_ovf = 1'b1;
                    end else begin
                        push      = 1'b1;
                        push_data = r_new;
                    end
                end
                n_state = S_IDLE;
            end
            S_EMIT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    load_out = 1'b1;
                    if (r_empty) begin
                        out_marker = 1'b1;
                        out_last   = 1'b1;
                    end else begin
                        pop      = 1'b1;
                        out_last = (r_cnt == CNT_W'(1));
                    end
                    if (out_last) begin
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        tail     = r_cnt - CNT_W'(pop);
        n_cnt    = tail + CNT_W'(push);
        n_ovalid = load_out ? 1'b1 : (r_ovalid && !i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_todo   <= '0;
            r_add    <= 1'b0;
            r_ovf    <= 1'b0;
            r_empty  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_todo   <= n_todo;
            r_add    <= n_add;
            r_ovf    <= n_ovf;
            r_empty  <= n_empty;
            r_ovalid <= n_ovalid;
        end
        if (r_state == S_DEC && dec_valid) begin
            r_new      <= dec_box;
            r_new_area <= dec_area;
        end
        if (load_out) begin
            r_obox       <= out_marker ? '0 : cell_q[0];
            r_obox_valid <= !out_marker;
            r_oovf       <= r_ovf;
            r_olast      <= out_last;
        end
    end

    for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
        assign cell_ctl[i].shift = pop;
        assign cell_ctl[i].load  = push && (tail == CNT_W'(i));
        obnf_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[i]),
            .i_next  ((i == MAX_BOXES - 1) ? push_data : cell_q[(i + 1) % MAX_BOXES]),
            .i_push  (push_data),
            .o_entry (cell_q[i])
        );
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {7'd0, r_oovf, r_obox.score, r_obox.height, r_obox.width,
                              r_obox.top, r_obox.left};
    assign o_m_axis_tuser  = r_obox_valid;
    assign o_m_axis_tlast  = r_olast;
endmodule

// File: dv/tb_online_box_nms_filter_core.sv
// self-checking testbench of the online box nms filter: directed and random frames, local model
`timescale 1ns / 1ps

module tb_online_box_nms_filter_core;
    import obnf_pkg::*;

    typedef struct {
        logic        func;
        bit [15:0]   score;
        bit [15:0]   ca;
        bit [15:0]   cb;
        bit [15:0]   cc;
        bit [15:0]   cd;
    } det_req_t;

    typedef struct {
        bit [13:0] left;
        bit [13:0] top;
        bit [13:0] width;
        bit [13:0] height;
        bit [15:0] score;
        bit        valid;
        bit        ovf;
        bit        last;
    } box_res_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [79:0]          i_s_axis_tdata;
    logic [0:0]           i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [79:0]          o_m_axis_tdata;
    logic [0:0]           o_m_axis_tuser;
    logic                 o_m_axis_tlast;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    online_box_nms_filter_core u_dut (.*);

    // predictor copy of registers and store
    bit        m_fmt;
    bit [12:0] m_imw, m_imh;
    bit [15:0] m_sthr, m_othr;
    bit [25:0] m_area;
    bit [7:0]  m_pad;
    longint    kl[MAX_BOXES], kt[MAX_BOXES], kw[MAX_BOXES], kh[MAX_BOXES];
    int        ks[MAX_BOXES];
    int        kcnt;
    bit        kovf;

    det_req_t  pending_dets[$];
    box_res_t  expected_boxes[$];
    int        errors, n_in, n_out, n_frames, n_ovf, gap, stall, idle_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint scaled(bit [15:0] c, bit [12:0] s);
        return (longint'(c) * longint'(s)) >>> 16;
    endfunction

    function automatic longint sat14(longint v);
        if (v > 8191) return 8191;
        if (v < -8192) return -8192;
        return v;
    endfunction

    function automatic bit overlaps(int j, longint l, longint t, longint w, longint h);
        longint x1, x2, y1, y2, inter, uni;
        x1 = (kl[j] > l) ? kl[j] : l;
        x2 = (kl[j] + kw[j] < l + w) ? kl[j] + kw[j] : l + w;
        y1 = (kt[j] > t) ? kt[j] : t;
        y2 = (kt[j] + kh[j] < t + h) ? kt[j] + kh[j] : t + h;
        if (x1 > x2 || y1 > y2) return 0;
        inter = (x2 - x1) * (y2 - y1);
        uni = kw[j] * kh[j] + w * h - inter;
        if (uni <= 0) return 0;
        return inter * 65536 > longint'(m_othr) * uni;
    endfunction

    task automatic nms_step(det_req_t d);
        longint   l, t, w, h, bw, bh, half, x0, y0, x1, y1;
        bit       add;
        box_res_t r;
        add = 1;
        if (d.func == FUNC_EOF) begin
            n_frames++;
            if (kcnt == 0) begin
                r = '{default: 0};
                r.ovf = kovf;
                r.last = 1;
                expected_boxes.insert(expected_boxes.size(), r);
            end else begin
                for (int k = 0; k < kcnt; k++) begin
                    r.left = kl[k][13:0];
                    r.top = kt[k][13:0];
                    r.width = kw[k][13:0];
                    r.height = kh[k][13:0];
                    r.score = ks[k][15:0];
                    r.valid = 1;
                    r.ovf = kovf;
                    r.last = (k + 1 == kcnt);
                    expected_boxes.insert(expected_boxes.size(), r);
                end
            end
            if (kovf) n_ovf++;
            kcnt = 0;
            kovf = 0;
            return;
        end
        if (d.score <= m_sthr) return;
        if (m_fmt == FMT_CENTER) begin
            bw = scaled(d.cc, m_imw) + longint'(m_pad);
            bh = scaled(d.cd, m_imh) + longint'(m_pad);
            l = sat14(scaled(d.ca, m_imw) - bw / 2);
            t = sat14(scaled(d.cb, m_imh) - bh / 2);
            w = sat14(bw);
            h = sat14(bh);
        end else begin
            half = longint'(m_pad) / 2;
            x0 = scaled(d.ca, m_imw) - half;
            y0 = scaled(d.cb, m_imh) - half;
            x1 = scaled(d.cc, m_imw) + half;
            y1 = scaled(d.cd, m_imh) + half;
            l = sat14(x0);
            t = sat14(y0);
            w = sat14(x1 - x0);
            h = sat14(y1 - y0);
            if (m_area != 0 && w * h > longint'(m_area)) add = 0;
        end
        for (int j = kcnt - 1; j >= 0; j--) begin
            if (overlaps(j, l, t, w, h)) begin
                if (ks[j] < int'(d.score)) begin
                    for (int i = j; i + 1 < kcnt; i++) begin
                        kl[i] = kl[i+1]; kt[i] = kt[i+1]; kw[i] = kw[i+1];
                        kh[i] = kh[i+1]; ks[i] = ks[i+1];
                    end
                    kcnt--;
                end else begin
                    add = 0;
                end
            end
        end
        if (add) begin
            if (kcnt >= MAX_BOXES) begin
                kovf = 1;
            end else begin
                kl[kcnt] = l; kt[kcnt] = t; kw[kcnt] = w; kh[kcnt] = h;
                ks[kcnt] = int'(d.score);
                kcnt++;
            end
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d: %s got %0h expected %0h", n_out, what, got, want);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            gap = 0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            nms_step('{i_s_axis_tuser[0], i_s_axis_tdata[15:0], i_s_axis_tdata[31:16],
                       i_s_axis_tdata[47:32], i_s_axis_tdata[63:48], i_s_axis_tdata[79:64]});
            n_in++;
            gap = pick_gap();
            if (gap == 0 && pending_dets.size() > 0) begin
                det_req_t d;
                d = pending_dets.pop_front();
                i_s_axis_tdata <= {d.cd, d.cc, d.cb, d.ca, d.score};
                i_s_axis_tuser <= d.func;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end else if (!i_s_axis_tvalid) begin
            if (gap > 0) begin
                gap--;
            end else if (pending_dets.size() > 0) begin
                det_req_t d;
                d = pending_dets.pop_front();
                i_s_axis_tdata <= {d.cd, d.cc, d.cb, d.ca, d.score};
                i_s_axis_tuser <= d.func;
                i_s_axis_tvalid <= 1'b1;
            end
        end
    end

    // result monitor and sink stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_boxes.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    box_res_t e;
                    e = expected_boxes.pop_front();
                    if (o_m_axis_tdata[13:0] !== e.left)
                        report_mismatch("left", longint'(o_m_axis_tdata[13:0]),
                                        longint'(e.left));
                    if (o_m_axis_tdata[27:14] !== e.top)
                        report_mismatch("top", longint'(o_m_axis_tdata[27:14]),
                                        longint'(e.top));
                    if (o_m_axis_tdata[41:28] !== e.width)
                        report_mismatch("width", longint'(o_m_axis_tdata[41:28]),
                                        longint'(e.width));
                    if (o_m_axis_tdata[55:42] !== e.height)
                        report_mismatch("height", longint'(o_m_axis_tdata[55:42]),
                                        longint'(e.height));
                    if (o_m_axis_tdata[71:56] !== e.score)
                        report_mismatch("score", longint'(o_m_axis_tdata[71:56]),
                                        longint'(e.score));
                    if (o_m_axis_tdata[72] !== e.ovf)
                        report_mismatch("overflow", longint'(o_m_axis_tdata[72]),
                                        longint'(e.ovf));
                    if (o_m_axis_tuser[0] !== e.valid)
                        report_mismatch("box_valid", longint'(o_m_axis_tuser[0]),
                                        longint'(e.valid));
                    if (o_m_axis_tlast !== e.last)
                        report_mismatch("last", longint'(o_m_axis_tlast), longint'(e.last));
                end
                n_out++;
            end
            if (stall > 0) begin
                stall--;
                i_m_axis_tready <= 1'b0;
            end else begin
                stall = pick_gap();
                i_m_axis_tready <= (stall == 0);
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 20000) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (pending_dets.size() > 0 || i_s_axis_tvalid || expected_boxes.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_BOX_FORMAT:   m_fmt = val[0];
            REG_IMAGE_WIDTH:  m_imw = val[12:0];
            REG_IMAGE_HEIGHT: m_imh = val[12:0];
            REG_SCORE_THR:    m_sthr = val[15:0];
            REG_OVERLAP_THR:  m_othr = val[15:0];
            REG_AREA_LIMIT:   m_area = val[25:0];
            REG_PAD_PIXELS:   m_pad = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_mode(bit fmt, int w, int h, int sthr, int othr, int area, int pad);
        wait_drained();
        write_reg(REG_BOX_FORMAT, CFG_W'(fmt));
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        write_reg(REG_SCORE_THR, CFG_W'(sthr));
        write_reg(REG_OVERLAP_THR, CFG_W'(othr));
        write_reg(REG_AREA_LIMIT, CFG_W'(area));
        write_reg(REG_PAD_PIXELS, CFG_W'(pad));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_det(bit [15:0] s, bit [15:0] a, bit [15:0] b, bit [15:0] c,
                            bit [15:0] d);
        pending_dets.insert(pending_dets.size(), '{FUNC_DET, s, a, b, c, d});
    endtask

    task automatic push_eof();
        pending_dets.insert(pending_dets.size(), '{FUNC_EOF, 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom)});
    endtask

    // frame of clustered boxes with random content, some noise items
    task automatic random_frame(int n);
        bit [15:0] a0, b0, c0, d0;
        a0 = 16'($urandom); b0 = 16'($urandom); c0 = 16'($urandom_range(0, 16000));
        d0 = 16'($urandom_range(0, 16000));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                push_det(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    a0 = 16'($urandom); b0 = 16'($urandom);
                end
                push_det(16'($urandom), 16'(a0 + $urandom_range(0, 2000)),
                         16'(b0 + $urandom_range(0, 2000)),
                         16'(c0 + $urandom_range(0, 3000)),
                         16'(d0 + $urandom_range(0, 3000)));
            end
        end
        push_eof();
    endtask

    initial begin
        m_fmt = FMT_CENTER; m_imw = 416; m_imh = 416; m_sthr = 6554; m_othr = 19661;
        m_area = 0; m_pad = 10;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty frame, threshold edge, extremes, suppression by score
        push_eof();
        push_det(6554, 30000, 30000, 8000, 8000);
        push_det(6555, 30000, 30000, 8000, 8000);
        push_det(6555, 30000, 30000, 8000, 8000);
        push_det(65535, 30000, 30000, 8000, 8000);
        push_det(20000, 30500, 30000, 8000, 8000);
        push_det(65535, 0, 0, 0, 0);
        push_det(65535, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_det(0, 16'hFFFF, 0, 16'hFFFF, 0);
        push_eof();
        push_eof();
        set_mode(FMT_CORNER, 4096, 4096, 0, 0, 100000, 255);
        push_det(40000, 1000, 1000, 1200, 1200);
        push_det(50000, 1000, 1000, 60000, 60000);
        push_det(1, 0, 0, 0, 0);
        push_det(65535, 16'hFFFF, 16'hFFFF, 0, 0);
        push_det(30000, 30000, 30000, 31000, 31000);
        push_eof();
        set_mode(FMT_CENTER, 4096, 1, 300, 65535, 0, 0);
        for (int i = 0; i < 36; i++) push_det(16'(1000 + i), 16'(i * 1800), 5000, 900, 0);
        push_eof();

        // random phases over several settings
        set_mode(FMT_CENTER, 416, 416, 6554, 19661, 0, 10);
        repeat (9) random_frame($urandom_range(0, 12));
        set_mode(FMT_CORNER, 640, 480, 1000, 30000, 20000, 6);
        repeat (6) random_frame($urandom_range(0, 12));
        set_mode(FMT_CENTER, 4096, 4096, 0, 0, 0, 255);
        repeat (6) random_frame($urandom_range(0, 12));
        set_mode(FMT_CORNER, 1, 1, 65000, 65535, 0, 0);
        repeat (4) random_frame($urandom_range(0, 12));
        set_mode(FMT_CENTER, 4096, 1, 300, 65535, 0, 0);
        repeat (3) random_frame($urandom_range(30, 40));
        set_mode(FMT_CORNER, 4096, 4096, 6554, 19661, 67108863, 255);
        repeat (6) random_frame($urandom_range(0, 12));
        set_mode(FMT_CORNER, 320, 240, 20000, 10000, 5000, 1);
        repeat (6) random_frame($urandom_range(0, 12));
        set_mode(FMT_CENTER, 1, 4096, 32768, 40000, 1, 0);
        repeat (5) random_frame($urandom_range(0, 12));

        wait_drained();
        $display("covered %0d requests in %0d frames, %0d results, %0d frames with overflow",
                 n_in, n_frames, n_out, n_ovf);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
design/obnf_pkg.sv
design/obnf_cell.sv
design/obnf_decode.sv
design/obnf_iou.sv
design/online_box_nms_filter_core.sv
dv/tb_online_box_nms_filter_core.sv
